### sv/ucpe_pkg.sv
// Shared types, codes and the encode function of the code point encoder.
package ucpe_pkg;

  // Output format register codes
  typedef enum logic [2:0] {
    FMT_NONE  = 3'd0,
    FMT_UTF8  = 3'd1,
    FMT_U16LE = 3'd2,
    FMT_U16BE = 3'd3,
    FMT_U32LE = 3'd4,
    FMT_U32BE = 3'd5,
    FMT_BAD6  = 3'd6,
    FMT_BAD7  = 3'd7
  } fmt_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFMT  = 2'd1,
    ST_BADCP  = 2'd2,
    ST_BADFMT = 2'd3
  } status_t;

  localparam int unsigned MaxBytes = 4;
  localparam int unsigned CntW     = 3;

  typedef logic [7:0] byte_t;

  // One encoded code point: bytes in stream order, byte count, status
  typedef struct packed {
    byte_t [MaxBytes-1:0] bytes;   // bytes[0] goes out first
    logic  [CntW-1:0]     cnt;
    status_t              status;
  } enc_t;

  localparam logic [31:0] MaxScalar = 32'h0010_FFFF;
  localparam logic [31:0] SurLo     = 32'h0000_D800;
  localparam logic [31:0] SurHi     = 32'h0000_DFFF;
  localparam logic [31:0] Plane1    = 32'h0001_0000;

  // Encode one code point in the given format
  function automatic enc_t encode(input logic [31:0] cp, input fmt_t fmt);
    enc_t        e;
    logic        bad_cp;
    logic [19:0] v;
    logic [15:0] u0;
    logic [15:0] u1;
    e        = '0;
    e.status = ST_OK;
    bad_cp   = (cp > MaxScalar) || ((cp >= SurLo) && (cp <= SurHi));
    v        = cp[19:0] - Plane1[19:0];
    u0       = cp[15:0];
    u1       = 16'h0000;
    if (cp >= Plane1) begin
      u0 = {6'b110110, v[19:10]};
      u1 = {6'b110111, v[9:0]};
    end
    case (fmt)
      FMT_NONE: begin
        e.cnt    = CntW'(1);
        e.status = ST_NOFMT;
      end
      FMT_U32LE: begin
        e.bytes = {cp[31:24], cp[23:16], cp[15:8], cp[7:0]};
        e.cnt   = CntW'(4);
      end
      FMT_U32BE: begin
        e.bytes = {cp[7:0], cp[15:8], cp[23:16], cp[31:24]};
        e.cnt   = CntW'(4);
      end
      FMT_UTF8: begin
        if (bad_cp) begin
          e.cnt    = CntW'(1);
          e.status = ST_BADCP;
        end else if (cp < 32'h80) begin
          e.bytes[0] = {1'b0, cp[6:0]};
          e.cnt      = CntW'(1);
        end else if (cp < 32'h800) begin
          e.bytes[0] = {3'b110, cp[10:6]};
          e.bytes[1] = {2'b10, cp[5:0]};
          e.cnt      = CntW'(2);
        end else if (cp < Plane1) begin
          e.bytes[0] = {4'b1110, cp[15:12]};
          e.bytes[1] = {2'b10, cp[11:6]};
          e.bytes[2] = {2'b10, cp[5:0]};
          e.cnt      = CntW'(3);
        end else begin
          e.bytes[0] = {5'b11110, cp[20:18]};
          e.bytes[1] = {2'b10, cp[17:12]};
          e.bytes[2] = {2'b10, cp[11:6]};
          e.bytes[3] = {2'b10, cp[5:0]};
          e.cnt      = CntW'(4);
        end
      end
      FMT_U16LE, FMT_U16BE: begin
        if (bad_cp) begin
          e.cnt    = CntW'(1);
          e.status = ST_BADCP;
        end else begin
          if (fmt == FMT_U16LE) begin
            e.bytes = {u1[15:8], u1[7:0], u0[15:8], u0[7:0]};
          end else begin
            e.bytes = {u1[7:0], u1[15:8], u0[7:0], u0[15:8]};
          end
          e.cnt = (cp >= Plane1) ? CntW'(4) : CntW'(2);
        end
      end
      default: begin
        e.cnt    = CntW'(1);
        e.status = ST_BADFMT;
      end
    endcase
    return e;
  endfunction

endpackage

### sv/unicode_code_point_encoder_unit.sv
// Top level of the Unicode code point encoder (UTF-8 / UTF-16 / UTF-32).
//
// Usage:
//   Input: drive in_code_point and raise start; the item is taken at a clock
//   edge where start is high and busy is low.
//   Output: each encoded byte appears for one cycle with out_valid high,
//   together with out_last_byte (final byte of the item) and out_status.
//   An error or a missing/invalid format yields one result, byte zero.
//   Config: cfg_wr_en with cfg_wr_data writes the output format register.
//   Write it only while the block is idle.
//   Path: an accepted item is loaded into the byte buffer; each byte then passes
//   the result register on its way to the output.
//   Throughput: an item has 1 to 4 bytes, and the single output byte port
//   sends one byte a cycle. The next item is taken in the cycle the last
//   byte of the current one moves out.
//   Reset (synchronous, rst_n low): byte buffer emptied, no result pending,
//   format set to UTF-8.
//   The receiver has no ready: every result must be taken as it is shown.
module unicode_code_point_encoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_code_point,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        out_last_byte,
  output logic [1:0]  out_status
);

  ucpe_pkg::fmt_t  fmt_r;
  ucpe_pkg::enc_t  enc;
  ucpe_pkg::enc_t  buf_r;
  ucpe_pkg::enc_t  buf_nxt;
  logic            load;
  logic            emit;
  logic            out_valid_r;
  logic [7:0]      out_byte_r;
  logic            out_last_r;
  logic [1:0]      out_status_r;

  // Format register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= ucpe_pkg::FMT_UTF8;
    end else if (cfg_wr_en) begin
      fmt_r <= ucpe_pkg::fmt_t'(cfg_wr_data);
    end
  end

  // Encode the incoming item
  assign enc  = ucpe_pkg::encode(in_code_point, fmt_r);
  assign emit = (buf_r.cnt != '0);
  assign busy = (buf_r.cnt > ucpe_pkg::CntW'(1));
  assign load = start && !busy;

  // Byte buffer: load on accept, else shift one byte out per cycle
  always_comb begin
    buf_nxt = buf_r;
    if (load) begin
      buf_nxt = enc;
    end else if (emit) begin
      buf_nxt.bytes = {8'h00, buf_r.bytes[ucpe_pkg::MaxBytes-1:1]};
      buf_nxt.cnt   = buf_r.cnt - ucpe_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r.cnt <= '0;
    end else begin
      buf_r.cnt <= buf_nxt.cnt;
    end
    buf_r.bytes  <= buf_nxt.bytes;
    buf_r.status <= buf_nxt.status;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
    end
    out_byte_r   <= buf_r.bytes[0];
    out_last_r   <= (buf_r.cnt == ucpe_pkg::CntW'(1));
    out_status_r <= buf_r.status;
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_valid_r && out_last_r;
  assign out_status    = out_status_r;

endmodule

### sv/ucpe_chk.sv
// Port-level assertions for the code point encoder, bound to the top level.
module ucpe_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic       out_last_byte,
  input logic [1:0] out_status
);

  // An error result is always the only, and so last, result of its item
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ucpe_pkg::ST_OK)) |-> out_last_byte)
    else $error("error result without last flag");

  // An accepted item shows its first byte after the byte buffer and the result register
  a_accept_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted item produced no result");

  // Bytes of one item come back to back until the last one
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_byte) |=> out_valid)
    else $error("gap inside an item's byte stream");

  // While busy, a byte is on its way out
  a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid)
    else $error("busy without output progress");

endmodule

bind unicode_code_point_encoder_unit ucpe_chk u_ucpe_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_last_byte (out_last_byte),
  .out_status    (out_status)
);

### tb/sv/unicode_code_point_encoder_unit_test.sv
// Testbench for the code point encoder: directed and random items, checked byte by byte.
`timescale 1ns / 1ps

module unicode_code_point_encoder_unit_test;

  // One expected output byte, tagged with the code point it came from
  typedef struct {
    logic [31:0]        cp;
    logic [7:0]         data;
    logic               last;
    ucpe_pkg::status_t  status;
  } byte_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_code_point = '0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_wr_data = '0;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last_byte;
  logic [1:0]  out_status;

  byte_result_t    pending_bytes[$];
  ucpe_pkg::fmt_t  active_fmt = ucpe_pkg::FMT_UTF8;  // register value after reset
  int              mismatch_count = 0;

  unicode_code_point_encoder_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_code_point (in_code_point),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte),
    .out_status    (out_status)
  );

  always #2 clk = ~clk;

  // Print one line per mismatch and count it
  task automatic flag_mismatch(input string what, input logic [31:0] cp,
                               input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: code point 0x%08h fmt %s got 0x%0h want 0x%0h",
             what, cp, active_fmt.name(), got, want);
    mismatch_count++;
  endtask

  function automatic void push_result(input logic [31:0] cp, input logic [7:0] data,
                                      input logic last, input ucpe_pkg::status_t st);
    byte_result_t r;
    r.cp     = cp;
    r.data   = data;
    r.last   = last;
    r.status = st;
    pending_bytes.push_back(r);
  endfunction

  // Expected byte stream of one code point under the current format
  function automatic void encode_expected(input logic [31:0] cp);
    logic [7:0]  seq [4];
    logic [15:0] units [2];
    logic [19:0] v;
    int          n;
    int          nunits;
    logic        bad_scalar;
    bad_scalar = (cp > 32'h0010_FFFF) || (cp >= 32'h0000_D800 && cp <= 32'h0000_DFFF);
    n = 0;
    case (active_fmt)
      ucpe_pkg::FMT_NONE: begin
        push_result(cp, 8'h00, 1'b1, ucpe_pkg::ST_NOFMT);
        return;
      end
      ucpe_pkg::FMT_BAD6, ucpe_pkg::FMT_BAD7: begin
        push_result(cp, 8'h00, 1'b1, ucpe_pkg::ST_BADFMT);
        return;
      end
      ucpe_pkg::FMT_U32LE: begin
        seq = '{cp[7:0], cp[15:8], cp[23:16], cp[31:24]};
        n = 4;
      end
      ucpe_pkg::FMT_U32BE: begin
        seq = '{cp[31:24], cp[23:16], cp[15:8], cp[7:0]};
        n = 4;
      end
      default: begin
        if (bad_scalar) begin
          push_result(cp, 8'h00, 1'b1, ucpe_pkg::ST_BADCP);
          return;
        end
        if (active_fmt == ucpe_pkg::FMT_UTF8) begin
          if (cp < 32'h80) begin
            seq[0] = cp[7:0];
            n = 1;
          end else if (cp < 32'h800) begin
            seq[0] = 8'hC0 | 8'(cp >> 6);
            seq[1] = 8'h80 | 8'(cp & 32'h3F);
            n = 2;
          end else if (cp < 32'h1_0000) begin
            seq[0] = 8'hE0 | 8'(cp >> 12);
            seq[1] = 8'h80 | 8'((cp >> 6) & 32'h3F);
            seq[2] = 8'h80 | 8'(cp & 32'h3F);
            n = 3;
          end else begin
            seq[0] = 8'hF0 | 8'(cp >> 18);
            seq[1] = 8'h80 | 8'((cp >> 12) & 32'h3F);
            seq[2] = 8'h80 | 8'((cp >> 6) & 32'h3F);
            seq[3] = 8'h80 | 8'(cp & 32'h3F);
            n = 4;
          end
        end else begin
          // UTF-16: one unit in the BMP, a surrogate pair above it
          if (cp < 32'h1_0000) begin
            units[0] = cp[15:0];
            units[1] = 16'h0000;
            nunits = 1;
          end else begin
            v = 20'(cp - 32'h1_0000);
            units[0] = 16'hD800 | 16'(v[19:10]);
            units[1] = 16'hDC00 | 16'(v[9:0]);
            nunits = 2;
          end
          for (int k = 0; k < nunits; k++) begin
            if (active_fmt == ucpe_pkg::FMT_U16LE) begin
              seq[2*k]   = units[k][7:0];
              seq[2*k+1] = units[k][15:8];
            end else begin
              seq[2*k]   = units[k][15:8];
              seq[2*k+1] = units[k][7:0];
            end
          end
          n = 2 * nunits;
        end
      end
    endcase
    for (int k = 0; k < n; k++) begin
      push_result(cp, seq[k], (k == n - 1), ucpe_pkg::ST_OK);
    end
  endfunction

  // Compare every strobed byte with the oldest expectation
  always @(posedge clk) begin
    byte_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_bytes.size() == 0) begin
        flag_mismatch("unexpected result", 32'h0, 32'(out_byte), 32'h0);
      end else begin
        want = pending_bytes.pop_front();
        if (out_byte !== want.data)
          flag_mismatch("out_byte", want.cp, 32'(out_byte), 32'(want.data));
        if (out_last_byte !== want.last)
          flag_mismatch("out_last_byte", want.cp, 32'(out_last_byte), 32'(want.last));
        if (out_status !== want.status)
          flag_mismatch("out_status", want.cp, 32'(out_status), 32'(want.status));
      end
    end
  end

  // Offer one item; optionally go idle after it is taken
  task automatic send_code_point(input logic [31:0] cp, input int idle_pct);
    start         <= 1'b1;
    in_code_point <= cp;
    do @(posedge clk); while (busy !== 1'b0);
    encode_expected(cp);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drop start if it is still raised from the last item
  task automatic stop_items();
    if (start) start <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  // Format register write; only called with start low
  task automatic set_format(input ucpe_pkg::fmt_t f);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= f;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    active_fmt = f;
  endtask

  function automatic logic [31:0] pick_code_point();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(32'h7F, 32'h0);
      1:       return $urandom_range(32'h7FF, 32'h80);
      2:       return $urandom_range(32'hD7FF, 32'h800);
      3:       return $urandom_range(32'hFFFF, 32'hE000);
      4:       return $urandom_range(32'hDFFF, 32'hD800);
      5, 6:    return $urandom_range(32'h10_FFFF, 32'h1_0000);
      7:       return $urandom_range(32'hFFFF_FFFF, 32'h11_0000);
      8:       return $urandom();
      default: begin
        case ($urandom_range(0, 13))
          0:       return 32'h0;
          1:       return 32'h7F;
          2:       return 32'h80;
          3:       return 32'h7FF;
          4:       return 32'h800;
          5:       return 32'hD7FF;
          6:       return 32'hD800;
          7:       return 32'hDFFF;
          8:       return 32'hE000;
          9:       return 32'hFFFF;
          10:      return 32'h1_0000;
          11:      return 32'h10_FFFF;
          12:      return 32'h11_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  // UTF-8 at the reset format: length boundaries, surrogates, out of range
  task automatic test_utf8_boundaries();
    logic [31:0] cps [11] = '{32'h0, 32'h7F, 32'h80, 32'h7FF, 32'h800, 32'hFFFF,
                              32'h1_0000, 32'h10_FFFF, 32'hD800, 32'hDFFF, 32'h11_0000};
    foreach (cps[i]) send_code_point(cps[i], 0);
    stop_items();
  endtask

  // UTF-16 byte order in both endians, with a surrogate pair and a lone surrogate
  task automatic test_utf16_order();
    set_format(ucpe_pkg::FMT_U16LE);
    send_code_point(32'h00E9, 0);
    send_code_point(32'h1_F600, 0);
    send_code_point(32'hDC00, 0);
    stop_items();
    set_format(ucpe_pkg::FMT_U16BE);
    send_code_point(32'hFFFF, 0);
    send_code_point(32'h10_FFFF, 0);
    stop_items();
  endtask

  // UTF-32 passes any value, surrogates and out of range included; the test sends out-of-range values
  task automatic test_utf32_passthrough();
    set_format(ucpe_pkg::FMT_U32LE);
    send_code_point(32'hFFFF_FFFF, 0);
    stop_items();
    set_format(ucpe_pkg::FMT_U32BE);
    send_code_point(32'h8000_D801, 0);
    stop_items();
  endtask

  // Format not set and the two invalid format codes
  task automatic test_format_errors();
    set_format(ucpe_pkg::FMT_NONE);
    send_code_point(32'h41, 0);
    stop_items();
    set_format(ucpe_pkg::FMT_BAD6);
    send_code_point(32'h41, 0);
    stop_items();
    set_format(ucpe_pkg::FMT_BAD7);
    send_code_point(32'hFFFF_FFFF, 0);
    stop_items();
  endtask

  // Random items in blocks, a random format per block
  task automatic test_random_stream(input int idle_pct, input int item_total);
    int              sent;
    int              block_len;
    int              pick;
    ucpe_pkg::fmt_t  f;
    sent = 0;
    while (sent < item_total) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)      f = ucpe_pkg::FMT_NONE;
      else if (pick == 1) f = $urandom_range(1) ? ucpe_pkg::FMT_BAD7 : ucpe_pkg::FMT_BAD6;
      else                f = ucpe_pkg::fmt_t'(3'($urandom_range(1, 5)));
      set_format(f);
      block_len = $urandom_range(6, 14);
      for (int i = 0; i < block_len && sent < item_total; i++) begin
        // now and then hold off until the output has fully drained
        if ($urandom_range(15) == 0) begin
          stop_items();
          wait_drained();
        end
        send_code_point(pick_code_point(), idle_pct);
        sent++;
      end
      stop_items();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_utf8_boundaries();
    test_utf16_order();
    test_utf32_passthrough();
    test_format_errors();
    test_random_stream(0, 80);
    test_random_stream(52, 80);
    test_random_stream(17, 70);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_bytes.size() == 0) begin
      $display("unicode_code_point_encoder_unit_test: done, clean");
    end else begin
      $display("unicode_code_point_encoder_unit_test: done, errors");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run
  initial begin
    #200000;
    $display("unicode_code_point_encoder_unit_test: done, errors");
    $finish;
  end

endmodule

### sim.f
sv/ucpe_pkg.sv
sv/unicode_code_point_encoder_unit.sv
sv/ucpe_chk.sv
tb/sv/unicode_code_point_encoder_unit_test.sv
